FILE: hw/rtl/tsmmt_pkg.sv
package tsmmt_pkg;

	localparam int NUM_STREAMS_DEF = 4;
	localparam int DEPTH_DEF = 16;
	localparam int TS_BITS_DEF = 48;
	localparam int NUM_REGS = 4;
	localparam int LIMIT_W = 5;

	localparam logic [2:0] ACT_INSERT = 3'd0;
	localparam logic [2:0] ACT_EXACT = 3'd1;
	localparam logic [2:0] ACT_WITHIN = 3'd2;
	localparam logic [2:0] ACT_CLOSEST = 3'd3;
	localparam logic [2:0] ACT_CLEAR = 3'd4;

	localparam logic [1:0] ST_SUCCESS = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_UNCONFIGURED = 2'd2;

	typedef struct packed {
		logic [2:0] action;
		logic [1:0] stream;
		logic [47:0] timestamp;
		logic [31:0] delta;
		logic [63:0] payload;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [47:0] found_timestamp;
		logic [63:0] found_payload;
	} result_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic eval;
		logic commit;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

FILE: hw/rtl/timestamp_matched_metadata_table_core.sv
// Each item is loaded, scanned, drained, committed and then put into the output register.
// One item is in work at a time; the scan reads one slot of the addressed stream per cycle
// through a single memory read port; no new item is taken until the last result is loaded.
// The next item is taken while a finished result still waits in the output register.
// Reset clears the limits, all slot valid bits and the control state at once; no clearing pass.
module timestamp_matched_metadata_table_core #(
	parameter int NUM_STREAMS = tsmmt_pkg::NUM_STREAMS_DEF,
	parameter int DEPTH = tsmmt_pkg::DEPTH_DEF,
	parameter int TS_BITS = tsmmt_pkg::TS_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input tsmmt_pkg::item_t item,
	output logic result_valid,
	input logic result_stall,
	output tsmmt_pkg::result_t result,
	input logic write_en,
	input logic [1:0] write_index,
	input logic [tsmmt_pkg::LIMIT_W-1:0] write_data
);

	tsmmt_pkg::ctl_cmd_t cmd;
	tsmmt_pkg::dp_sts_t sts;
	logic [$clog2(DEPTH)-1:0] rd_idx;

	tsmmt_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.sts(sts),
		.cmd(cmd),
		.rd_idx(rd_idx)
	);

	tsmmt_dp #(
		.NUM_STREAMS(NUM_STREAMS),
		.DEPTH(DEPTH),
		.TS_BITS(TS_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.write_en(write_en),
		.write_index(write_index),
		.write_data(write_data),
		.cmd(cmd),
		.rd_idx(rd_idx),
		.sts(sts),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

FILE: hw/rtl/tsmmt_ctrl.sv
module tsmmt_ctrl #(
	parameter int DEPTH = tsmmt_pkg::DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input tsmmt_pkg::dp_sts_t sts,
	output tsmmt_pkg::ctl_cmd_t cmd,
	output logic [$clog2(DEPTH)-1:0] rd_idx
);

	localparam int IW = $clog2(DEPTH);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [IW-1:0] idx_q;
	logic eval_s1;

	assign item_stall = (state_q != S_IDLE);
	assign rd_idx = idx_q;

	always_comb begin
		cmd.load = (state_q == S_IDLE) && item_valid;
		cmd.rd = (state_q == S_SCAN);
		cmd.eval = eval_s1;
		cmd.commit = (state_q == S_COMMIT);
		cmd.out_load = (state_q == S_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			eval_s1 <= 1'b0;
		end else begin
			eval_s1 <= (state_q == S_SCAN);
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (item_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IW'(DEPTH - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/tsmmt_dp.sv
module tsmmt_dp #(
	parameter int NUM_STREAMS = tsmmt_pkg::NUM_STREAMS_DEF,
	parameter int DEPTH = tsmmt_pkg::DEPTH_DEF,
	parameter int TS_BITS = tsmmt_pkg::TS_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input tsmmt_pkg::item_t item,
	input logic write_en,
	input logic [1:0] write_index,
	input logic [tsmmt_pkg::LIMIT_W-1:0] write_data,
	input tsmmt_pkg::ctl_cmd_t cmd,
	input logic [$clog2(DEPTH)-1:0] rd_idx,
	output tsmmt_pkg::dp_sts_t sts,
	output logic result_valid,
	input logic result_stall,
	output tsmmt_pkg::result_t result
);

	localparam int IW = $clog2(DEPTH);
	localparam int NUM_SLOTS = NUM_STREAMS * DEPTH;
	localparam int AW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [TS_BITS-1:0] TS_MASK = {TS_BITS{1'b1}};

	logic [TS_BITS-1:0] ts_mem [NUM_SLOTS];
	logic [63:0] pl_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;
	logic [tsmmt_pkg::LIMIT_W-1:0] limit_q [tsmmt_pkg::NUM_REGS];

	logic [2:0] action_q;
	logic [1:0] stream_q;
	logic [TS_BITS-1:0] ts_q, lo_q, hi_q;
	logic [63:0] pl_q;
	logic [CW-1:0] lim_q;
	logic unconf_q;

	logic [TS_BITS-1:0] ts_s1;
	logic [63:0] pl_s1;
	logic v_s1;
	logic [IW-1:0] idx_s1;

	logic match_q, free_f_q, min_f_q, bef_f_q, aft_f_q;
	logic [IW-1:0] match_idx_q, free_idx_q, min_idx_q;
	logic [63:0] match_pl_q, bef_pl_q, aft_pl_q;
	logic [TS_BITS-1:0] min_ts_q, bef_ts_q, aft_ts_q;
	logic [CW-1:0] count_q;

	logic result_valid_q;
	tsmmt_pkg::result_t result_q, res_c;

	logic [64:0] tsx, dx, sumx;
	logic [TS_BITS-1:0] ts_in, lo_c, hi_c;
	logic [8:0] lim_raw;
	logic [CW-1:0] lim_c;
	logic unconf_c;
	logic [AW-1:0] base, rd_addr, wr_addr;
	logic mem_we, set_valid;
	logic [IW-1:0] wr_idx;

	assign ts_in = TS_BITS'(item.timestamp);
	assign tsx = 65'(ts_in);
	assign dx = 65'(item.delta);
	assign sumx = tsx + dx;

	always_comb begin
		lo_c = (tsx >= dx) ? TS_BITS'(tsx - dx) : '0;
		hi_c = (sumx > 65'(TS_MASK)) ? TS_MASK : TS_BITS'(sumx);
		if (item.action == tsmmt_pkg::ACT_CLOSEST) begin
			lo_c = '0;
			hi_c = TS_MASK;
		end
		lim_raw = 9'(limit_q[item.stream]);
		if (lim_raw > 9'(DEPTH)) begin
			lim_raw = 9'(DEPTH);
		end
		unconf_c = (32'(item.stream) >= NUM_STREAMS) || (lim_raw == 9'd0);
		lim_c = CW'(lim_raw);
	end

	assign base = AW'(AW'(stream_q) * AW'(DEPTH));
	assign rd_addr = base + AW'(rd_idx);

	always_comb begin
		mem_we = 1'b0;
		set_valid = 1'b0;
		wr_idx = match_idx_q;
		if (cmd.commit && !unconf_q && action_q == tsmmt_pkg::ACT_INSERT) begin
			if (match_q) begin
				mem_we = 1'b1;
			end else if (count_q < lim_q && free_f_q) begin
				mem_we = 1'b1;
				set_valid = 1'b1;
				wr_idx = free_idx_q;
			end else if (min_f_q && !(ts_q < min_ts_q)) begin
				mem_we = 1'b1;
				wr_idx = min_idx_q;
			end
		end
	end

	assign wr_addr = base + AW'(wr_idx);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ts_mem[wr_addr] <= ts_q;
			pl_mem[wr_addr] <= pl_q;
		end
		if (cmd.rd) begin
			ts_s1 <= ts_mem[rd_addr];
			pl_s1 <= pl_mem[rd_addr];
			v_s1 <= valid_q[rd_addr];
			idx_s1 <= rd_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int r = 0; r < tsmmt_pkg::NUM_REGS; r++) begin
				limit_q[r] <= '0;
			end
		end else begin
			if (write_en) begin
				limit_q[write_index] <= write_data;
				for (int k = 0; k < NUM_SLOTS; k++) begin
					if (32'(k / DEPTH) == 32'(write_index)) begin
						valid_q[k] <= 1'b0;
					end
				end
			end
			if (set_valid) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.commit && !unconf_q && action_q == tsmmt_pkg::ACT_CLEAR) begin
				for (int k = 0; k < NUM_SLOTS; k++) begin
					if (AW'(k / DEPTH) == AW'(stream_q)) begin
						valid_q[k] <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			free_f_q <= 1'b0;
			min_f_q <= 1'b0;
			bef_f_q <= 1'b0;
			aft_f_q <= 1'b0;
			count_q <= '0;
			unconf_q <= 1'b0;
			action_q <= tsmmt_pkg::ACT_INSERT;
			stream_q <= '0;
		end else if (cmd.load) begin
			match_q <= 1'b0;
			free_f_q <= 1'b0;
			min_f_q <= 1'b0;
			bef_f_q <= 1'b0;
			aft_f_q <= 1'b0;
			count_q <= '0;
			unconf_q <= unconf_c;
			action_q <= item.action;
			stream_q <= unconf_c ? 2'd0 : item.stream;
		end else if (cmd.eval) begin
			if (v_s1) begin
				count_q <= count_q + 1'b1;
				if (ts_s1 == ts_q && !match_q) begin
					match_q <= 1'b1;
				end
				if (!min_f_q || ts_s1 < min_ts_q) begin
					min_f_q <= 1'b1;
				end
				if (ts_s1 >= lo_q && ts_s1 < ts_q) begin
					bef_f_q <= 1'b1;
				end else if (ts_s1 >= ts_q && ts_s1 <= hi_q) begin
					aft_f_q <= 1'b1;
				end
			end else if (!free_f_q) begin
				free_f_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ts_q <= ts_in;
			lo_q <= lo_c;
			hi_q <= hi_c;
			pl_q <= item.payload;
			lim_q <= lim_c;
		end else if (cmd.eval) begin
			if (v_s1) begin
				if (ts_s1 == ts_q && !match_q) begin
					match_idx_q <= idx_s1;
					match_pl_q <= pl_s1;
				end
				if (!min_f_q || ts_s1 < min_ts_q) begin
					min_idx_q <= idx_s1;
					min_ts_q <= ts_s1;
				end
				if (ts_s1 >= lo_q && ts_s1 < ts_q) begin
					if (!bef_f_q || ts_s1 > bef_ts_q) begin
						bef_ts_q <= ts_s1;
						bef_pl_q <= pl_s1;
					end
				end else if (ts_s1 >= ts_q && ts_s1 <= hi_q) begin
					if (!aft_f_q || ts_s1 < aft_ts_q) begin
						aft_ts_q <= ts_s1;
						aft_pl_q <= pl_s1;
					end
				end
			end else if (!free_f_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	always_comb begin
		res_c = '0;
		if (unconf_q) begin
			res_c.status = tsmmt_pkg::ST_UNCONFIGURED;
		end else begin
			unique case (action_q)
				tsmmt_pkg::ACT_INSERT, tsmmt_pkg::ACT_CLEAR: begin
					res_c.status = tsmmt_pkg::ST_SUCCESS;
				end
				tsmmt_pkg::ACT_EXACT: begin
					if (match_q) begin
						res_c.status = tsmmt_pkg::ST_SUCCESS;
						res_c.found_timestamp = 48'(ts_q);
						res_c.found_payload = match_pl_q;
					end else begin
						res_c.status = tsmmt_pkg::ST_NOT_FOUND;
					end
				end
				tsmmt_pkg::ACT_WITHIN, tsmmt_pkg::ACT_CLOSEST: begin
					if (bef_f_q) begin
						res_c.status = tsmmt_pkg::ST_SUCCESS;
						res_c.found_timestamp = 48'(bef_ts_q);
						res_c.found_payload = bef_pl_q;
					end else if (aft_f_q) begin
						res_c.status = tsmmt_pkg::ST_SUCCESS;
						res_c.found_timestamp = 48'(aft_ts_q);
						res_c.found_payload = aft_pl_q;
					end else begin
						res_c.status = tsmmt_pkg::ST_NOT_FOUND;
					end
				end
				default: begin
					res_c.status = tsmmt_pkg::ST_NOT_FOUND;
				end
			endcase
		end
	end

	assign sts.out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q <= res_c;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

FILE: tb/timestamp_matched_metadata_table_core_tb.sv
module timestamp_matched_metadata_table_core_tb;

	localparam int STREAMS = 4;
	localparam int SLOTS = 16;
	localparam logic [47:0] TS_MAX = 48'hFFFF_FFFF_FFFF;
	localparam int SETTLE_CYCLES = 30;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		tsmmt_pkg::item_t it;
		bit typed;
		tsmmt_pkg::result_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	tsmmt_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	tsmmt_pkg::result_t result;
	logic write_en = 1'b0;
	logic [1:0] write_index = '0;
	logic [tsmmt_pkg::LIMIT_W-1:0] write_data = '0;

	int limit_of [STREAMS];
	logic [47:0] entry_ts [STREAMS][SLOTS];
	logic [63:0] entry_pl [STREAMS][SLOTS];
	bit entry_used [STREAMS][SLOTS];

	tsmmt_pkg::result_t pending_results[$];
	row_t directed[$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	bit quiet = 0;
	bit hold_long = 0;
	int rx_pause = 0;

	timestamp_matched_metadata_table_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.write_en(write_en),
		.write_index(write_index),
		.write_data(write_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %0h, expected %0h", what, got, want);
		errors++;
	endtask

	function automatic void wipe_stream(int s);
		for (int i = 0; i < SLOTS; i++)
			entry_used[s][i] = 0;
	endfunction

	// Latest entry in [lo, ts), else the earliest one in [ts, hi].
	function automatic int window_hit(int s, logic [47:0] ts, logic [47:0] lo, logic [47:0] hi);
		int below;
		int above;
		below = -1;
		above = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!entry_used[s][i])
				continue;
			if (entry_ts[s][i] >= lo && entry_ts[s][i] < ts) begin
				if (below < 0 || entry_ts[s][i] > entry_ts[s][below])
					below = i;
			end else if (entry_ts[s][i] >= ts && entry_ts[s][i] <= hi) begin
				if (above < 0 || entry_ts[s][i] < entry_ts[s][above])
					above = i;
			end
		end
		return below >= 0 ? below : above;
	endfunction

	function automatic tsmmt_pkg::result_t predict_lookup(tsmmt_pkg::item_t it);
		tsmmt_pkg::result_t r;
		int s;
		int lim;
		int hit;
		int count;
		int free_slot;
		int min_slot;
		logic [48:0] upper;
		logic [47:0] lo;
		logic [47:0] hi;
		r = '0;
		s = int'(it.stream);
		lim = limit_of[s] > SLOTS ? SLOTS : limit_of[s];
		hit = -1;
		if (lim == 0) begin
			r.status = tsmmt_pkg::ST_UNCONFIGURED;
			return r;
		end
		r.status = tsmmt_pkg::ST_SUCCESS;
		case (it.action)
			tsmmt_pkg::ACT_INSERT: begin
				count = 0;
				free_slot = -1;
				min_slot = -1;
				for (int i = 0; i < SLOTS; i++) begin
					if (entry_used[s][i]) begin
						if (entry_ts[s][i] == it.timestamp) begin
							entry_pl[s][i] = it.payload;
							return r;
						end
						count++;
						if (min_slot < 0 || entry_ts[s][i] < entry_ts[s][min_slot])
							min_slot = i;
					end else if (free_slot < 0) begin
						free_slot = i;
					end
				end
				if (count < lim && free_slot >= 0) begin
					entry_used[s][free_slot] = 1;
					entry_ts[s][free_slot] = it.timestamp;
					entry_pl[s][free_slot] = it.payload;
				end else if (min_slot >= 0 && it.timestamp >= entry_ts[s][min_slot]) begin
					entry_ts[s][min_slot] = it.timestamp;
					entry_pl[s][min_slot] = it.payload;
				end
				return r;
			end
			tsmmt_pkg::ACT_EXACT: begin
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && entry_used[s][i] && entry_ts[s][i] == it.timestamp)
						hit = i;
			end
			tsmmt_pkg::ACT_WITHIN: begin
				lo = it.timestamp >= 48'(it.delta) ? it.timestamp - 48'(it.delta) : '0;
				upper = {1'b0, it.timestamp} + 49'(it.delta);
				hi = upper > 49'(TS_MAX) ? TS_MAX : upper[47:0];
				hit = window_hit(s, it.timestamp, lo, hi);
			end
			tsmmt_pkg::ACT_CLOSEST: hit = window_hit(s, it.timestamp, '0, TS_MAX);
			tsmmt_pkg::ACT_CLEAR: begin
				wipe_stream(s);
				return r;
			end
			default: begin
				r.status = tsmmt_pkg::ST_NOT_FOUND;
				return r;
			end
		endcase
		if (hit < 0) begin
			r.status = tsmmt_pkg::ST_NOT_FOUND;
		end else begin
			r.found_timestamp = entry_ts[s][hit];
			r.found_payload = entry_pl[s][hit];
		end
		return r;
	endfunction

	function automatic tsmmt_pkg::item_t mk(logic [2:0] a, int s, logic [47:0] ts,
		logic [31:0] d, logic [63:0] pl);
		tsmmt_pkg::item_t it;
		it.action = a;
		it.stream = s[1:0];
		it.timestamp = ts;
		it.delta = d;
		it.payload = pl;
		return it;
	endfunction

	function automatic void add_row(tsmmt_pkg::item_t it, bit typed, logic [1:0] st,
		logic [47:0] fts, logic [63:0] fpl);
		row_t r;
		r.it = it;
		r.typed = typed;
		r.want.status = st;
		r.want.found_timestamp = fts;
		r.want.found_payload = fpl;
		directed.push_back(r);
	endfunction

	task automatic send(tsmmt_pkg::item_t it, bit typed, tsmmt_pkg::result_t want);
		int gap;
		tsmmt_pkg::result_t r;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall);
		r = predict_lookup(it);
		pending_results.push_back(typed ? want : r);
		items_sent++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(int idx, int val);
		drain();
		write_en <= 1'b1;
		write_index <= idx[1:0];
		write_data <= val[tsmmt_pkg::LIMIT_W-1:0];
		@(posedge clk);
		write_en <= 1'b0;
		limit_of[idx] = val;
		wipe_stream(idx);
	endtask

	function automatic tsmmt_pkg::item_t random_item();
		tsmmt_pkg::item_t it;
		int pick;
		it.stream = 2'($urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		if (pick < 40)
			it.action = tsmmt_pkg::ACT_INSERT;
		else if (pick < 58)
			it.action = tsmmt_pkg::ACT_EXACT;
		else if (pick < 78)
			it.action = tsmmt_pkg::ACT_WITHIN;
		else if (pick < 92)
			it.action = tsmmt_pkg::ACT_CLOSEST;
		else if (pick < 97)
			it.action = tsmmt_pkg::ACT_CLEAR;
		else
			it.action = 3'($urandom_range(5, 7));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			it.timestamp = 48'({$urandom(), $urandom()});
		else if (pick == 1)
			it.timestamp = TS_MAX - 48'($urandom_range(0, 40));
		else
			it.timestamp = 48'h1000 + 48'($urandom_range(0, 60));
		it.delta = $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 30);
		it.payload = {$urandom(), $urandom()};
		return it;
	endfunction

	initial begin
		forever begin
			@(posedge clk);
			if (hold_long) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_long = 0;
			end
			if (result_valid && !result_stall)
				rx_pause = quiet ? 0 : $urandom_range(0, 13);
			if (rx_pause > 0) begin
				result_stall <= 1'b1;
				rx_pause--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report("unexpected result", 64'(result.status), 64'd0);
			end else begin
				if (result.status !== pending_results[0].status)
					report("status", 64'(result.status), 64'(pending_results[0].status));
				if (result.found_timestamp !== pending_results[0].found_timestamp)
					report("found_timestamp", 64'(result.found_timestamp),
						64'(pending_results[0].found_timestamp));
				if (result.found_payload !== pending_results[0].found_payload)
					report("found_payload", result.found_payload,
						pending_results[0].found_payload);
				void'(pending_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		tsmmt_pkg::result_t none;
		int lims [4];
		none = '0;
		for (int s = 0; s < STREAMS; s++) begin
			limit_of[s] = 0;
			wipe_stream(s);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(mk(tsmmt_pkg::ACT_INSERT, 0, 48'd7, 32'd0, 64'd9), 1,
			'{tsmmt_pkg::ST_UNCONFIGURED, 48'd0, 64'd0});
		set_limit(0, 2);
		set_limit(1, 16);
		set_limit(2, 31);
		set_limit(3, 1);

		add_row(mk(tsmmt_pkg::ACT_INSERT, 0, 48'd100, 0, 64'hA), 1, tsmmt_pkg::ST_SUCCESS,
			0, 0);
		add_row(mk(tsmmt_pkg::ACT_INSERT, 0, TS_MAX, 0, '1), 1, tsmmt_pkg::ST_SUCCESS, 0, 0);
		add_row(mk(tsmmt_pkg::ACT_INSERT, 0, 48'd50, 0, 64'hB), 1, tsmmt_pkg::ST_SUCCESS,
			0, 0);
		add_row(mk(tsmmt_pkg::ACT_EXACT, 0, 48'd50, 0, 0), 1, tsmmt_pkg::ST_NOT_FOUND, 0, 0);
		add_row(mk(tsmmt_pkg::ACT_EXACT, 0, TS_MAX, 0, 0), 1, tsmmt_pkg::ST_SUCCESS,
			TS_MAX, '1);
		add_row(mk(tsmmt_pkg::ACT_WITHIN, 0, 48'd150, 32'd60, 0), 0, 0, 0, 0);
		add_row(mk(tsmmt_pkg::ACT_WITHIN, 0, 48'd0, '1, 0), 0, 0, 0, 0);
		add_row(mk(tsmmt_pkg::ACT_WITHIN, 0, TS_MAX, '1, 0), 0, 0, 0, 0);
		add_row(mk(tsmmt_pkg::ACT_CLOSEST, 0, 48'd0, 0, 0), 0, 0, 0, 0);
		add_row(mk(3'd5, 0, 48'd100, 0, 0), 1, tsmmt_pkg::ST_NOT_FOUND, 0, 0);
		add_row(mk(3'd7, 1, TS_MAX, '1, '1), 1, tsmmt_pkg::ST_NOT_FOUND, 0, 0);
		add_row(mk(tsmmt_pkg::ACT_INSERT, 0, 48'd100, 0, 64'hC0FFEE), 1,
			tsmmt_pkg::ST_SUCCESS, 0, 0);
		add_row(mk(tsmmt_pkg::ACT_EXACT, 0, 48'd100, 0, 0), 0, 0, 0, 0);
		add_row(mk(tsmmt_pkg::ACT_INSERT, 3, 48'd0, 0, 0), 1, tsmmt_pkg::ST_SUCCESS, 0, 0);
		add_row(mk(tsmmt_pkg::ACT_INSERT, 3, 48'd5, 0, 64'h5), 1, tsmmt_pkg::ST_SUCCESS,
			0, 0);
		add_row(mk(tsmmt_pkg::ACT_CLOSEST, 3, TS_MAX, 0, 0), 0, 0, 0, 0);
		add_row(mk(tsmmt_pkg::ACT_CLEAR, 0, 0, 0, 0), 1, tsmmt_pkg::ST_SUCCESS, 0, 0);
		add_row(mk(tsmmt_pkg::ACT_EXACT, 0, 48'd100, 0, 0), 1, tsmmt_pkg::ST_NOT_FOUND, 0, 0);
		add_row(mk(tsmmt_pkg::ACT_WITHIN, 1, 48'd100, 32'd10, 0), 1, tsmmt_pkg::ST_NOT_FOUND,
			0, 0);
		add_row(mk(tsmmt_pkg::ACT_CLOSEST, 2, 48'd100, 0, 0), 1, tsmmt_pkg::ST_NOT_FOUND,
			0, 0);
		foreach (directed[i])
			send(directed[i].it, directed[i].typed, directed[i].want);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: lims = '{16, 3, 1, 0};
				1: lims = '{31, 16, 2, 5};
				2: lims = '{4, 0, 16, 31};
				default: foreach (lims[s]) lims[s] = $urandom_range(0, 31);
			endcase
			foreach (lims[s])
				set_limit(s, lims[s]);
			quiet = (ph == 2);
			if (ph == 0)
				hold_long = 1;
			repeat (80)
				send(random_item(), 0, none);
		end

		drain();
		$display("Run covered %0d items and %0d results over 5 limit settings,", items_sent,
			results_seen);
		$display("including a long receiver hold and a phase with no idling.");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
